// File: rtl/fba_pkg.sv
// Shared types and constants for the bitmap frame allocator.
// No dependencies; imported by every module of the block.
package fba_pkg;

    localparam int FRAME_W = 12;
    localparam int COUNT_W = 13;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [FRAME_W-1:0] current_frame;
        logic               kernel_only;
        logic               wr_allowed;
    } t_item;

    typedef struct packed {
        logic [FRAME_W-1:0] new_frame;
        logic               present;
        logic               writable;
        logic               user_access;
        logic               updated;
        logic               no_free_frame;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_SEEK,
        ST_FREE_WR
    } t_state;

    typedef enum logic [2:0] {
        RES_MAPPED,
        RES_EMPTY,
        RES_FULL,
        RES_ALLOC,
        RES_FREED
    } t_res_kind;

    typedef struct packed {
        logic      load_item;
        logic      rst_ptr;
        logic      step;
        logic      clr_wr;
        logic      set_bit_wr;
        logic      clr_bit_wr;
        logic      emit;
        t_res_kind kind;
    } t_dp_cmd;

    typedef struct packed {
        logic opcode;
        logic cur_zero;
        logic cur_in_store;
        logic clr_last;
        logic pend;
        logic word_in_range;
        logic word_has_free;
        logic free_hit;
    } t_dp_sts;

endpackage

// File: rtl/fba_datapath.sv
// Datapath of the frame allocator: bitmap memory, word pointer, item and result registers.
// Depends on fba_pkg; driven by fba_ctrl through t_dp_cmd.
module fba_datapath #(
    parameter int MAX_FRAMES = 4096,
    parameter int WORD_BITS  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fba_pkg::t_item                 i_item,
    input  logic                           i_cfg_we,
    input  logic [fba_pkg::COUNT_W-1:0]    i_cfg_wdata,
    input  fba_pkg::t_dp_cmd               i_cmd,
    output fba_pkg::t_dp_sts               o_sts,
    output logic                           o_valid,
    output fba_pkg::t_result               o_result
);
    import fba_pkg::*;

    localparam int DEPTH  = MAX_FRAMES / WORD_BITS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam int OFF_W  = $clog2(WORD_BITS);
    localparam int BASE_W = $clog2(MAX_FRAMES + WORD_BITS + 1);
    localparam int CMP_W  = (BASE_W > COUNT_W) ? BASE_W : COUNT_W;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    logic [COUNT_W-1:0] r_frame_count;
    t_item              r_item;
    logic [IDX_W-1:0]   r_idx,  n_idx;
    logic [BASE_W-1:0]  r_base, n_base;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_rd_idx;
    logic [BASE_W-1:0]  r_rd_base;
    logic               r_rd_inrange;
    logic               r_valid;
    t_result            r_result, n_result;

    logic                 in_range;
    logic [OFF_W-1:0]     free_pos;
    logic [OFF_W-1:0]     off;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_frame_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        n_idx  = r_idx;
        n_base = r_base;
        n_pend = r_pend;
        if (i_cmd.rst_ptr) begin
            n_idx  = '0;
            n_base = '0;
            n_pend = 1'b0;
        end else if (i_cmd.step) begin
            n_idx  = IDX_W'(r_idx + 1'b1);
            n_base = BASE_W'(r_base + BASE_W'(WORD_BITS));
            n_pend = 1'b1;
        end
    end

    // a word counts only if it lies wholly below frame_count and within storage
    assign in_range = (CMP_W'(r_base) + CMP_W'(WORD_BITS) <= CMP_W'(r_frame_count))
                      && (r_idx < IDX_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_base <= '0;
            r_pend <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_base <= n_base;
            r_pend <= n_pend;
        end
    end

    // track which word the registered read data belongs to
    always_ff @(posedge i_clk) begin
        r_rd_idx     <= r_idx[AW-1:0];
        r_rd_base    <= r_base;
        r_rd_inrange <= in_range;
    end

    // lowest clear bit of the word under test
    always_comb begin
        free_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (!r_rdata[j]) begin
                free_pos = OFF_W'(j);
            end
        end
    end

    assign off = OFF_W'(CMP_W'(r_item.current_frame) - CMP_W'(r_base));

    assign wr_en   = i_cmd.clr_wr | i_cmd.set_bit_wr | i_cmd.clr_bit_wr;
    assign wr_addr = i_cmd.set_bit_wr ? r_rd_idx : r_idx[AW-1:0];

    always_comb begin
        if (i_cmd.clr_wr) begin
            wr_data = '0;
        end else if (i_cmd.set_bit_wr) begin
            wr_data = r_rdata | (WORD_BITS'(1) << free_pos);
        end else begin
            wr_data = r_rdata & ~(WORD_BITS'(1) << off);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[r_idx[AW-1:0]];
    end

    always_comb begin
        n_result = '0;
        case (i_cmd.kind)
            RES_MAPPED: n_result.new_frame = r_item.current_frame;
            RES_FULL:   n_result.no_free_frame = 1'b1;
            RES_ALLOC: begin
                n_result.new_frame   = FRAME_W'(r_rd_base + BASE_W'(free_pos));
                n_result.present     = 1'b1;
                n_result.writable    = r_item.wr_allowed;
                n_result.user_access = ~r_item.kernel_only;
                n_result.updated     = 1'b1;
            end
            RES_FREED:  n_result.updated = 1'b1;
            default:    n_result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    assign o_sts.opcode        = r_item.opcode;
    assign o_sts.cur_zero      = (r_item.current_frame == '0);
    assign o_sts.cur_in_store  = (CMP_W'(r_item.current_frame) < CMP_W'(MAX_FRAMES));
    assign o_sts.clr_last      = (r_idx[AW-1:0] == AW'(DEPTH - 1));
    assign o_sts.pend          = r_pend;
    assign o_sts.word_in_range = r_rd_inrange;
    assign o_sts.word_has_free = ~(&r_rdata);
    assign o_sts.free_hit      = (CMP_W'(r_item.current_frame)
                                  < CMP_W'(r_base) + CMP_W'(WORD_BITS));

endmodule

// File: rtl/fba_ctrl.sv
// Control state machine of the frame allocator: clearing pass, scan, seek and write-back.
// Depends on fba_pkg; commands fba_datapath.
module fba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  fba_pkg::t_dp_sts  i_sts,
    output fba_pkg::t_dp_cmd  o_cmd
);
    import fba_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_sts.opcode == OP_ALLOC) begin
                    n_state = i_sts.cur_zero ? ST_SCAN : ST_IDLE;
                end else begin
                    n_state = (!i_sts.cur_zero && i_sts.cur_in_store) ? ST_SEEK : ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (i_sts.pend && (!i_sts.word_in_range || i_sts.word_has_free)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SEEK: begin
                if (i_sts.free_hit) n_state = ST_FREE_WR;
            end
            ST_FREE_WR: n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.kind = RES_EMPTY;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                o_cmd.step   = 1'b1;
            end
            ST_IDLE: begin
                o_cmd.load_item = start;
            end
            ST_DECIDE: begin
                o_cmd.rst_ptr = 1'b1;
                if (i_sts.opcode == OP_ALLOC) begin
                    if (!i_sts.cur_zero) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.kind = RES_MAPPED;
                    end
                end else if (i_sts.cur_zero) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = RES_EMPTY;
                end else if (!i_sts.cur_in_store) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = RES_FREED;
                end
            end
            ST_SCAN: begin
                if (i_sts.pend && !i_sts.word_in_range) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = RES_FULL;
                end else if (i_sts.pend && i_sts.word_has_free) begin
                    o_cmd.set_bit_wr = 1'b1;
                    o_cmd.emit       = 1'b1;
                    o_cmd.kind       = RES_ALLOC;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_SEEK: begin
                // hold the pointer on the matching word so its read lands next cycle
                o_cmd.step = ~i_sts.free_hit;
            end
            ST_FREE_WR: begin
                o_cmd.clr_bit_wr = 1'b1;
                o_cmd.emit       = 1'b1;
                o_cmd.kind       = RES_FREED;
            end
            default: o_cmd = '0;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

endmodule

// File: rtl/frame_bitmap_allocator_core.sv
// Top level of the bitmap frame allocator: joins controller and datapath.
// Depends on fba_pkg, fba_ctrl and fba_datapath.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------
//  request   | start / busy         | i_item   (t_item)
//  result    | o_valid (one cycle)  | o_result (t_result)
//  config    | i_cfg_we             | i_cfg_wdata (frame_count)
//
// An item is taken when start is high and busy is low. Allocation walks the bitmap
// one word per cycle through the single read port until a word with a free bit
// or the first word outside frame_count ends the scan. A free walks to the frame's word
// the same way, then writes that word back with the frame's bit cleared. Trivial
// requests are answered from the decide state. After reset a clearing pass over
// every bitmap word holds busy high.
// Each result shows for exactly one cycle; the receiver cannot stall.
module frame_bitmap_allocator_core #(
    parameter int MAX_FRAMES = 4096,
    parameter int WORD_BITS  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  fba_pkg::t_item               i_item,
    output logic                         o_valid,
    output fba_pkg::t_result             o_result,
    input  logic                         i_cfg_we,
    input  logic [fba_pkg::COUNT_W-1:0]  i_cfg_wdata
);
    import fba_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    fba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fba_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

endmodule

// File: tb/frame_bitmap_allocator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for frame_bitmap_allocator_core: a queued request driver,
// a result monitor and an in-bench bitmap predictor. Depends on fba_pkg and the RTL.
module frame_bitmap_allocator_core_tb;
    import fba_pkg::*;

    localparam int MAX_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = MAX_FRAMES / WORD_BITS;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               start       = 1'b0;
    logic               busy;
    t_item              i_item      = '0;
    logic               o_valid;
    t_result            o_result;
    logic               i_cfg_we    = 1'b0;
    logic [COUNT_W-1:0] i_cfg_wdata = '0;

    // predictor state
    logic [WORD_BITS-1:0] used_map [MAP_WORDS] = '{default: '0};
    logic [COUNT_W-1:0]   frames_managed = COUNT_RESET;

    t_item   entry_requests[$];
    t_result entry_updates[$];

    int burst_left = 1;
    int gap_left   = 0;
    int errors     = 0;
    int n_alloc    = 0;
    int n_full     = 0;
    int n_mapped   = 0;
    int n_freed    = 0;
    int n_empty    = 0;
    int n_checked  = 0;

    frame_bitmap_allocator_core #(
        .MAX_FRAMES(MAX_FRAMES),
        .WORD_BITS (WORD_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Entry update for one request; marks or clears the frame in the predictor's bitmap.
    function automatic t_result allocate_or_free(t_item req);
        t_result upd;
        int      words;
        upd = '0;
        if (req.opcode == OP_ALLOC) begin
            if (req.current_frame != '0) begin
                upd.new_frame = req.current_frame;
                n_mapped++;
                return upd;
            end
            words = int'(frames_managed) / WORD_BITS;
            if (words > MAP_WORDS) words = MAP_WORDS;
            for (int w = 0; w < words; w++) begin
                for (int b = 0; b < WORD_BITS; b++) begin
                    if (!used_map[w][b]) begin
                        used_map[w][b]  = 1'b1;
                        upd.new_frame   = FRAME_W'(w * WORD_BITS + b);
                        upd.present     = 1'b1;
                        upd.writable    = req.wr_allowed;
                        upd.user_access = ~req.kernel_only;
                        upd.updated     = 1'b1;
                        n_alloc++;
                        return upd;
                    end
                end
            end
            upd.no_free_frame = 1'b1;
            n_full++;
        end else if (req.current_frame == '0) begin
            n_empty++;
        end else begin
            used_map[req.current_frame / WORD_BITS][req.current_frame % WORD_BITS] = 1'b0;
            upd.updated = 1'b1;
            n_freed++;
        end
        return upd;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic queue_request(logic op, int frame, logic kern, logic wr);
        t_item req;
        req.opcode        = op;
        req.current_frame = FRAME_W'(frame);
        req.kernel_only   = kern;
        req.wr_allowed    = wr;
        entry_requests.push_back(req);
    endtask

    // Drain everything, then let the block settle before touching the register.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (entry_requests.size() != 0 || entry_updates.size() != 0 || start || busy);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_frame_count(int value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= COUNT_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        frames_managed = COUNT_W'(value);
    endtask

    // Driver: bursts of requests separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                entry_updates.push_back(allocate_or_free(i_item));
            end
            if (start && busy) begin
                // hold the item until the block takes it
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (entry_requests.size() != 0) begin
                start  <= 1'b1;
                i_item <= entry_requests.pop_front();
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result is taken and checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (entry_updates.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_result);
                errors++;
            end else begin
                t_result want;
                want = entry_updates.pop_front();
                n_checked++;
                check_field("new_frame", want.new_frame, o_result.new_frame);
                check_field("present", want.present, o_result.present);
                check_field("writable", want.writable, o_result.writable);
                check_field("user_access", want.user_access, o_result.user_access);
                check_field("updated", want.updated, o_result.updated);
                check_field("no_free_frame", want.no_free_frame, o_result.no_free_frame);
            end
        end
    end

    initial begin
        int    phase_counts [7] = '{32, 33, 64, 4096, 8191, 96, 32};
        int    hi;
        t_item req;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // hold off until the clearing pass has finished
        do @(negedge i_clk);
        while (busy !== 1'b0);

        // one word with a ragged tail
        write_frame_count(40);
        queue_request(OP_ALLOC, 0, 1'b0, 1'b1);
        queue_request(OP_ALLOC, 0, 1'b1, 1'b0);
        queue_request(OP_ALLOC, 0, 1'b1, 1'b1);
        queue_request(OP_ALLOC, 4095, 1'b1, 1'b1);
        queue_request(OP_ALLOC, 'h800, 1'b0, 1'b0);
        queue_request(OP_FREE, 0, 1'b1, 1'b1);
        queue_request(OP_FREE, 1, 1'b0, 1'b1);
        queue_request(OP_ALLOC, 0, 1'b0, 1'b0);
        queue_request(OP_FREE, 4095, 1'b0, 1'b0);
        queue_request(OP_FREE, 2, 1'b1, 1'b0);
        queue_request(OP_ALLOC, 0, 1'b1, 1'b1);
        queue_request(OP_FREE, 'h555, 1'b0, 1'b1);
        queue_request(OP_FREE, 'hAAA, 1'b1, 1'b0);
        wait_idle();

        // nothing to scan: every allocation of frame 0 reports a full bitmap
        write_frame_count(0);
        queue_request(OP_ALLOC, 0, 1'b0, 1'b1);
        queue_request(OP_FREE, 5, 1'b0, 1'b0);
        queue_request(OP_ALLOC, 1, 1'b1, 1'b1);
        wait_idle();
        write_frame_count(31);
        queue_request(OP_ALLOC, 0, 1'b1, 1'b1);
        wait_idle();

        // word count saturates at the stored depth
        write_frame_count(8191);
        queue_request(OP_ALLOC, 0, 1'b0, 1'b1);
        queue_request(OP_FREE, 3, 1'b1, 1'b1);
        wait_idle();

        foreach (phase_counts[p]) begin
            write_frame_count(phase_counts[p]);
            hi = ((frames_managed < 256) ? int'(frames_managed) : 256) + 31;
            if (hi > MAX_FRAMES - 1) hi = MAX_FRAMES - 1;
            repeat (110) begin
                req.opcode      = ($urandom_range(0, 9) < 6) ? OP_ALLOC : OP_FREE;
                req.kernel_only = 1'($urandom);
                req.wr_allowed  = 1'($urandom);
                if (req.opcode == OP_ALLOC) begin
                    req.current_frame = ($urandom_range(0, 9) < 7) ? '0 : FRAME_W'($urandom);
                end else begin
                    case ($urandom_range(0, 9))
                        0:       req.current_frame = '0;
                        1:       req.current_frame = FRAME_W'($urandom);
                        default: req.current_frame = FRAME_W'($urandom_range(0, hi));
                    endcase
                end
                entry_requests.push_back(req);
            end
            wait_idle();
        end

        $display("Checked %0d results over 11 frame-count settings from 0 to 8191.", n_checked);
        $display("Allocated %0d, full %0d, mapped %0d, freed %0d, empty frees %0d.",
                 n_alloc, n_full, n_mapped, n_freed, n_empty);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: frame_bitmap_allocator_core.f
rtl/fba_pkg.sv
rtl/fba_datapath.sv
rtl/fba_ctrl.sv
rtl/frame_bitmap_allocator_core.sv
tb/frame_bitmap_allocator_core_tb.sv
